@@ sv/wmm_pkg.sv @@
`default_nettype none
package wmm_pkg;
  localparam int MAX_WINDOW = 16;
  localparam int COORD_BITS = 32;
  localparam int AXES       = 3;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = COORD_BITS + ADDR_W + 1;
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int SAMPLE_W   = AXES * COORD_BITS;
  localparam int WLEN_W     = 5;
  localparam int FILL_W     = 5;
  localparam int IN_W       = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W      = ((SAMPLE_W + FILL_W + 7) / 8) * 8;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_WLEN = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } sample_t;

  typedef struct packed {
    logic             mode;
    logic [CNT_W-1:0] len;
    logic             clear;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_MEDIAN,
    ST_DIV,
    ST_DONE
  } back_state_t;

  function automatic logic [CNT_W-1:0] eff_len(input logic [WLEN_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) r = CNT_W'(1);
    else if (32'(w) > MAX_WINDOW) r = CNT_W'(MAX_WINDOW);
    else r = CNT_W'(w);
    return r;
  endfunction

  function automatic coord_t axis_of(input sample_t s, input int a);
    logic [SAMPLE_W-1:0] v;
    v = s;
    return coord_t'(v[a*COORD_BITS +: COORD_BITS]);
  endfunction
endpackage
`default_nettype wire

@@ sv/wmm_ram.sv @@
`default_nettype none
module wmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/wmm_front.sv @@
`default_nettype none
// Two-entry sample queue between the input channel and the filter engine.
module wmm_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wmm_pkg::sample_t in_data,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output wmm_pkg::sample_t      q_data
);
  import wmm_pkg::*;

  sample_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ sv/wmm_div.sv @@
`default_nettype none
// Three-lane restoring divider: signed sum over a small unsigned count,
// one quotient bit per cycle, truncating toward zero.
module wmm_div (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [wmm_pkg::SUM_W-1:0]       dividend [wmm_pkg::AXES],
  input  wire logic        [wmm_pkg::CNT_W-1:0]       divisor,
  output logic                                        done,
  output wmm_pkg::coord_t                             quotient [wmm_pkg::AXES]
);
  import wmm_pkg::*;

  logic [CNT_W:0]      rem  [AXES];
  logic [SUM_W-1:0]    quo  [AXES];
  logic                neg  [AXES];
  logic [CNT_W-1:0]    dv;
  logic [STEP_W-1:0]   step;
  logic                busy;
  logic [CNT_W+1:0]    trial [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      trial[a] = {rem[a], quo[a][SUM_W-1]} - {2'b00, dv};
      quotient[a] = neg[a] ? coord_t'(-quo[a]) : coord_t'(quo[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv <= divisor;
      for (int a = 0; a < AXES; a++) begin
        neg[a] <= dividend[a][SUM_W-1];
        quo[a] <= dividend[a][SUM_W-1] ? SUM_W'(-dividend[a]) : SUM_W'(dividend[a]);
        rem[a] <= '0;
      end
    end else if (busy) begin
      for (int a = 0; a < AXES; a++) begin
        if (!trial[a][CNT_W+1]) rem[a] <= trial[a][CNT_W:0];
        else rem[a] <= {rem[a][CNT_W-1:0], quo[a][SUM_W-1]};
        quo[a] <= {quo[a][SUM_W-2:0], ~trial[a][CNT_W+1]};
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/wmm_back.sv @@
`default_nettype none
// Filter engine: stores the sample, reads the window back, then sorts for
// the median or divides the sum for the mean, and holds the result.
module wmm_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire wmm_pkg::cfg_t               cfg,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  input  wire wmm_pkg::sample_t            q_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output wmm_pkg::coord_t                  out_filt [wmm_pkg::AXES],
  output logic [wmm_pkg::FILL_W-1:0]       out_fill
);
  import wmm_pkg::*;

  back_state_t state, state_next;

  logic [ADDR_W-1:0]     write_slot;
  logic [CNT_W-1:0]      samples_held;
  logic [CNT_W-1:0]      n;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      slot;
  logic [CNT_W-1:0]      slot_inc;
  logic                  rd_pend;
  logic [SAMPLE_W-1:0]   rd_data;
  logic signed [SUM_W-1:0] sum [AXES];
  coord_t                sbuf [MAX_WINDOW][AXES];
  coord_t                lo   [AXES];
  coord_t                res  [AXES];
  coord_t                quot [AXES];
  logic [CNT_W-1:0]      half;
  logic                  div_start;
  logic                  div_go;
  logic                  div_done;
  logic                  med_hit;
  logic                  load_end;
  logic                  sort_end;
  logic                  out_free;
  logic [COORD_BITS:0]   pair [AXES];

  assign slot     = (CNT_W'(write_slot) >= cfg.len) ? '0 : CNT_W'(write_slot);
  assign slot_inc = slot + CNT_W'(1);
  assign half     = n >> 1;
  assign load_end = (idx == n);
  assign sort_end = (idx == CNT_W'(MAX_WINDOW - 1));
  assign med_hit  = (idx == half);
  assign out_free = !out_valid || out_ready;
  // The divider starts in the first divide cycle, once the last window entry
  // has been added into the sums.
  assign div_start = div_go;

  wmm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_store (
    .clk   (clk),
    .we    (q_pop),
    .waddr (slot[ADDR_W-1:0]),
    .wdata (q_data),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  wmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (n),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && !cfg.clear) begin
          q_pop      = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:   if (load_end) state_next = cfg.mode ? ST_DIV : ST_SORT;
      ST_SORT:   if (sort_end) state_next = ST_MEDIAN;
      ST_MEDIAN: if (med_hit) state_next = ST_DONE;
      ST_DIV:    if (div_done) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      pair[a] = {lo[a][COORD_BITS-1], lo[a]} + {sbuf[0][a][COORD_BITS-1], sbuf[0][a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx <= '0;
        for (int a = 0; a < AXES; a++) sum[a] <= '0;
        for (int i = 0; i < MAX_WINDOW; i++)
          for (int a = 0; a < AXES; a++) sbuf[i][a] <= {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      ST_LOAD: begin
        if (!load_end) idx <= idx + CNT_W'(1);
        else idx <= '0;
        if (rd_pend) begin
          for (int a = 0; a < AXES; a++) begin
            sum[a] <= sum[a] + SUM_W'(axis_of(sample_t'(rd_data), a));
            sbuf[MAX_WINDOW-1][a] <= axis_of(sample_t'(rd_data), a);
            for (int i = 0; i < MAX_WINDOW - 1; i++) sbuf[i][a] <= sbuf[i+1][a];
          end
        end
      end
      ST_SORT: begin
        idx <= sort_end ? '0 : idx + CNT_W'(1);
        for (int i = 0; i < MAX_WINDOW - 1; i++) begin
          if ((i % 2) == int'(idx[0])) begin
            for (int a = 0; a < AXES; a++) begin
              if (sbuf[i][a] > sbuf[i+1][a]) begin
                sbuf[i][a]   <= sbuf[i+1][a];
                sbuf[i+1][a] <= sbuf[i][a];
              end
            end
          end
        end
      end
      ST_MEDIAN: begin
        idx <= idx + CNT_W'(1);
        for (int a = 0; a < AXES; a++) begin
          for (int i = 0; i < MAX_WINDOW - 1; i++) sbuf[i][a] <= sbuf[i+1][a];
          lo[a] <= sbuf[0][a];
          if (med_hit) res[a] <= n[0] ? sbuf[0][a] : coord_t'(pair[a][COORD_BITS:1]);
        end
      end
      ST_DIV: begin
        if (div_done) for (int a = 0; a < AXES; a++) res[a] <= quot[a];
      end
      ST_DONE: begin
        if (out_free) begin
          for (int a = 0; a < AXES; a++) out_filt[a] <= res[a];
          out_fill <= FILL_W'(n);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) n <= (samples_held < cfg.len) ? samples_held + CNT_W'(1) : samples_held;
    if (rst) begin
      write_slot   <= '0;
      samples_held <= '0;
      rd_pend      <= 1'b0;
      div_go       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_pend <= (state == ST_LOAD) && !load_end;
      div_go  <= (state == ST_LOAD) && load_end && cfg.mode;
      if (cfg.clear) begin
        write_slot   <= '0;
        samples_held <= '0;
      end else if (q_pop) begin
        write_slot <= (slot_inc >= cfg.len) ? '0 : slot_inc[ADDR_W-1:0];
        if (samples_held < cfg.len) samples_held <= samples_held + CNT_W'(1);
      end
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ sv/window_median_mean_3axis_top.sv @@
`default_nettype none
// Three-axis sliding-window median or mean filter for position samples.
// Input transactions arrive on the s_axis group: tdata carries pos_x, pos_y
// and pos_z, signed 32 bits each. Every accepted sample enters a window of
// up to window_length recent samples, replacing the oldest once it is full.
// One result transaction per sample leaves on the m_axis group: the per-axis
// median (mode 0) or mean (mode 1) of the window and the fill count.
// The engine reads the window store back, one entry per cycle, then sorts it
// in sixteen transposition passes for the median or divides the sums in the
// bit-serial divider for the mean. One sample is worked at a time; the engine
// takes no new sample until the previous result is registered for output.
// A two-entry input queue keeps accepting while the engine works, and the
// result register holds a finished result until the receiver takes it.
// If m_axis_tready stays low the engine waits, the queue fills, and
// s_axis_tready drops. Reset empties the window and queue, sets mode to
// median and window_length to 16. The user must write configuration over
// the APB port only while the block is idle; the block does not enforce it.
// Any register write empties the window.
module window_median_mean_3axis_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [wmm_pkg::IN_W-1:0]     s_axis_tdata,  // pos_x, pos_y, pos_z
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [wmm_pkg::OUT_W-1:0]         m_axis_tdata,  // filt_x, filt_y, filt_z,
                                                           // fill_count, zero pad
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import wmm_pkg::*;

  logic              mode;
  logic [WLEN_W-1:0] wlen;
  logic              wr_en;
  cfg_t              cfg;
  logic              q_valid;
  logic              q_pop;
  sample_t           q_data;
  coord_t            filt [AXES];
  logic [FILL_W-1:0] fill;

  // Registers sit at byte addresses 0 and 4; only address bit 2 decodes.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_WLEN) ? {{(32-WLEN_W){1'b0}}, wlen} : {31'd0, mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      wlen <= WLEN_W'(MAX_WINDOW);
    end else if (wr_en) begin
      if (paddr[2] == REG_MODE) mode <= pwdata[0];
      else wlen <= pwdata[WLEN_W-1:0];
    end
  end

  assign cfg.mode  = mode;
  assign cfg.len   = eff_len(wlen);
  assign cfg.clear = wr_en;

  wmm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (sample_t'(s_axis_tdata[SAMPLE_W-1:0])),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  wmm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_filt  (filt),
    .out_fill  (fill)
  );

  assign m_axis_tdata = {(OUT_W - SAMPLE_W - FILL_W)'(0), fill, filt[2], filt[1], filt[0]};
endmodule
`default_nettype wire

@@ tb/window_filter_checker.sv @@
module window_filter_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [wmm_pkg::IN_W-1:0] in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [wmm_pkg::OUT_W-1:0] out_data,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_addr,
  input  logic [31:0]              cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       results_seen
);
  import wmm_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic [FILL_W-1:0] fill;
  } filtered_t;

  filtered_t awaited[$];
  coord_t win_x[MAX_WINDOW];
  coord_t win_y[MAX_WINDOW];
  coord_t win_z[MAX_WINDOW];
  int slot, held, span;
  logic avg_mode;
  logic [WLEN_W-1:0] wlen;

  function automatic coord_t median_of(input coord_t v[MAX_WINDOW], input int n);
    longint b[MAX_WINDOW];
    longint t;
    int i, j;
    for (i = 0; i < n; i++) b[i] = longint'(v[i]);
    for (i = 1; i < n; i++) begin
      t = b[i];
      j = i;
      while (j > 0 && b[j-1] > t) begin
        b[j] = b[j-1];
        j--;
      end
      b[j] = t;
    end
    if (n % 2 == 1) return coord_t'(b[n/2]);
    return coord_t'((b[n/2] + b[n/2-1]) >>> 1);
  endfunction

  function automatic coord_t mean_of(input coord_t v[MAX_WINDOW], input int n);
    longint s;
    s = 0;
    for (int i = 0; i < n; i++) s += longint'(v[i]);
    return coord_t'(s / n);
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    filtered_t e;
    filtered_t got;
    if (rst) begin
      awaited.delete();
      slot = 0;
      held = 0;
      avg_mode = 1'b0;
      wlen = 5'd16;
      errors <= 0;
      results_seen <= 0;
    end else begin
      // Only address bit 2 selects the register, as in the block.
      if (cfg_write) begin
        if (cfg_addr[2] == REG_MODE) avg_mode = cfg_data[0];
        else wlen = cfg_data[WLEN_W-1:0];
        slot = 0;
        held = 0;
      end
      if (in_valid && in_ready) begin
        span = int'(eff_len(wlen));
        if (slot >= span) slot = 0;
        win_x[slot] = coord_t'(in_data[31:0]);
        win_y[slot] = coord_t'(in_data[63:32]);
        win_z[slot] = coord_t'(in_data[95:64]);
        slot = (slot + 1 >= span) ? 0 : slot + 1;
        if (held < span) held++;
        e.x = avg_mode ? mean_of(win_x, held) : median_of(win_x, held);
        e.y = avg_mode ? mean_of(win_y, held) : median_of(win_y, held);
        e.z = avg_mode ? mean_of(win_z, held) : median_of(win_z, held);
        e.fill = FILL_W'(held);
        awaited.insert(awaited.size(), e);
      end
      if (out_valid && out_ready) begin
        got.x = coord_t'(out_data[31:0]);
        got.y = coord_t'(out_data[63:32]);
        got.z = coord_t'(out_data[95:64]);
        got.fill = out_data[100:96];
        results_seen <= results_seen + 1;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d fill=%0d",
                   $time, got.x, got.y, got.z, got.fill);
          errors <= errors + 1;
        end else begin
          e = awaited.pop_front();
          if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.fill !== e.fill) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d fill=%0d",
                     $time, e.x, e.y, e.z, e.fill);
            $display("%0t:          actual   x=%0d y=%0d z=%0d fill=%0d",
                     $time, got.x, got.y, got.z, got.fill);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_window_median_mean_3axis_top.sv @@
module tb_window_median_mean_3axis_top;
  import wmm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;  // pos_x, pos_y, pos_z
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;  // filt_x, filt_y, filt_z, fill_count, pad
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int errors, pending, results_seen;
  int samples_sent = 0;
  int quiet_cycles = 0;
  // While calm is set neither side idles, which gives back-to-back traffic.
  logic calm = 1'b0;

  always #5 clk = ~clk;

  window_median_mean_3axis_top DUT (.*);

  window_filter_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .cfg_write(psel && penable && pwrite && pready), .cfg_addr(paddr),
    .cfg_data(pwdata), .errors(errors), .pending(pending),
    .results_seen(results_seen)
  );

  // The receiver stalls at random with a chance of about 15 in a hundred.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 15);
  end

  // The watchdog ends the run if no transaction of any kind completes for
  // far longer than the slowest sample could take under full stalling.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("tb_window_median_mean_3axis_top NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord(input int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(20)) - 32'd10;
      3: return 32'h8000_0000 + 32'($urandom_range(3));
      4: return 32'h7FFF_FFFF - 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Sends one sample and holds tvalid until the transaction completes.
  task automatic send_sample(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
    if (!calm && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic avg, input logic [31:0] len);
    drain();
    cfg_write(3'(4 * REG_MODE), {$urandom_range(1) ? 31'h7FFF_FFFF : 31'd0, avg});
    cfg_write(3'(4 * REG_WLEN), len);
  endtask

  initial begin
    logic [31:0] len;
    int kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: reset settings, full-scale extremes, odd and even fills.
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'h1);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_sample(32'd3, 32'hFFFF_FFFD, 32'h8000_0000);
    // Mean mode with sums beyond 32 bits and negative truncation toward zero.
    set_filter(1'b1, 32'd4);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE);
    send_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF);
    send_sample(32'd5, 32'd7, 32'hFFFF_FFF9);
    // A window length of zero acts as one, and above sixteen saturates.
    set_filter(1'b0, 32'd0);
    send_sample(32'd1, 32'd2, 32'd3);
    send_sample(32'hFFFF_FFFF, 32'd5, 32'h8000_0000);
    set_filter(1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_sample(pick_coord(i), pick_coord(5), pick_coord(i % 3));
    // Addresses that differ only in the low bits alias; both writes here go to the window length register.
    drain();
    cfg_write(3'd4, 32'hFFFF_FFFF);
    cfg_write(3'd7, 32'h0);
    send_sample(32'd9, 32'd9, 32'd9);
    send_sample(32'hFFFF_FFF7, 32'd0, 32'd1);

    // Random part in phases, each with its own mode and window length.
    // The sender pauses at every phase change until all results are in.
    for (int phase = 0; phase < 24; phase++) begin
      case (phase % 6)
        0: len = 32'd1;
        1: len = 32'd16;
        2: len = 32'd2;
        3: len = 32'($urandom_range(31));
        default: len = 32'($urandom_range(1, 16));
      endcase
      set_filter(phase[0] ^ phase[2], len);
      calm = (phase == 9);
      for (int i = 0; i < 75; i++) begin
        kind = ($urandom_range(99) < 70) ? 5 : $urandom_range(4);
        send_sample(pick_coord(kind), pick_coord($urandom_range(5)),
                    pick_coord($urandom_range(5)));
      end
      calm = 1'b0;
    end
    drain();

    $display("Sent %0d samples and checked %0d results over median and mean",
             samples_sent, results_seen);
    $display("modes with window lengths from zero up past the maximum.");
    if (errors == 0 && pending == 0)
      $display("tb_window_median_mean_3axis_top OK");
    else
      $display("tb_window_median_mean_3axis_top NOT OK");
    $finish;
  end
endmodule
